// ===== rtl/core/stx_length_xor_frame_receiver_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the STX frame receiver
// Immediate-implication and next-cycle-implication checks on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef STX_LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH
`define STX_LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define STXLXFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define STXLXFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STXLXFR_ASSERT_NOW(lbl, ante, cons, msg)
`define STXLXFR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/stxlxfr_pkg.sv =====
// ---------------------------------------------------------------------------
// STX frame receiver package
// Result codes, register indexes and the result record.
// ---------------------------------------------------------------------------
package stxlxfr_pkg;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_ENABLE = 1'd1;

    localparam logic [7:0] START_BYTE_RST = 8'd2;
    localparam logic       SEQ_ENABLE_RST = 1'b1;

    // header bytes: start, length low, length high, [sequence], message id
    localparam logic [2:0] HDR_NO_SEQ = 3'd4;
    localparam logic [2:0] HDR_SEQ    = 3'd5;

    typedef enum logic
    {
        KIND_PAYLOAD,
        KIND_FRAME_END
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK,
        STATUS_CHECKSUM,
        STATUS_OVERSIZE
    } status_t;

    typedef struct packed
    {
        kind_t       result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  message_id;
        logic [7:0]  sequence_res;
        logic [15:0] payload_length;
        status_t     frame_status;
    } result_t;

endpackage

// ===== rtl/core/stxlxfr_in_if.sv =====
// ---------------------------------------------------------------------------
// STX receive byte channel
// Valid/ready channel carrying one received byte per transaction.
// ---------------------------------------------------------------------------
interface stxlxfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/stxlxfr_out_if.sv =====
// ---------------------------------------------------------------------------
// STX result channel
// Valid/ready channel carrying payload bytes and frame-end status.
// ---------------------------------------------------------------------------
interface stxlxfr_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [7:0]  message_id;
    logic [7:0]  sequence_res;
    logic [15:0] payload_length;
    logic [1:0]  frame_status;

    modport source (output valid, output result_kind, output payload_byte,
                    output byte_index, output message_id, output sequence_res,
                    output payload_length, output frame_status, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input byte_index, input message_id, input sequence_res,
                    input payload_length, input frame_status, output ready);
endinterface

// ===== rtl/core/stx_length_xor_frame_receiver.sv =====
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register sets the pace.
// A byte is taken whenever the output register is empty or being emptied this cycle.
// Reset clears the frame state (hunting), empties the output register and
// restores start_byte to 2 and seq_enable to 1.
// ---------------------------------------------------------------------------
// STX length/XOR frame receiver
// Hunts for the start byte, parses the length/sequence/id header, passes
// payload bytes on as they arrive and reports a status at the checksum byte.
// ---------------------------------------------------------------------------
`include "stx_length_xor_frame_receiver_defines.svh"

module stx_length_xor_frame_receiver #(
    parameter int BUFFER_BYTES = 256,
    parameter int MAX_PAYLOAD  = 251
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [stxlxfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stxlxfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    stxlxfr_in_if.sink                          rx,
    stxlxfr_out_if.source                       res
);

    // Frame byte counter holds 0..BUFFER_BYTES; the end compare needs room
    // for a 16-bit length plus header plus checksum.
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int EW = (CW > 17) ? CW : 17;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [7:0] start_byte_reg;
    logic       seq_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= stxlxfr_pkg::START_BYTE_RST;
            seq_enable_reg <= stxlxfr_pkg::SEQ_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stxlxfr_pkg::CFG_START_BYTE: start_byte_reg <= cfg_wdata[7:0];
                stxlxfr_pkg::CFG_SEQ_ENABLE: seq_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Frame state
    // -----------------------------------------------------------------------
    logic [CW-1:0] byte_count_reg,      byte_count_next;
    logic [15:0]   declared_length_reg, declared_length_next;
    logic [7:0]    length_low_reg,      length_low_next;
    logic [7:0]    running_xor_reg,     running_xor_next;
    logic [7:0]    held_id_reg,         held_id_next;
    logic [7:0]    held_sequence_reg,   held_sequence_next;

    // Output register
    logic                 res_valid_reg, res_valid_next;
    stxlxfr_pkg::result_t res_data_reg,  res_data_next;

    logic                 rx_accept;
    logic                 res_load;
    stxlxfr_pkg::result_t res_new;

    // Take a new byte while the output register is free or draining
    assign rx.ready  = !res_valid_reg || res.ready;
    assign rx_accept = rx.valid && rx.ready;

    // -----------------------------------------------------------------------
    // Per-byte frame parsing
    // -----------------------------------------------------------------------
    always_comb
    begin
        logic [7:0]    b;
        logic [2:0]    header;
        logic [CW-1:0] count_inc;
        logic [EW-1:0] count_ext;
        logic [EW-1:0] header_ext;
        logic [EW-1:0] total;
        logic [EW-1:0] payload_last;
        logic [EW-1:0] payload_pos;
        logic [15:0]   decl_cur;

        b            = rx.rx_byte;
        header       = seq_enable_reg ? stxlxfr_pkg::HDR_SEQ : stxlxfr_pkg::HDR_NO_SEQ;
        count_inc    = byte_count_reg + CW'(1);
        count_ext    = EW'(count_inc);
        header_ext   = EW'(header);
        decl_cur     = (count_inc == CW'(3)) ? {b, length_low_reg} : declared_length_reg;
        total        = EW'(decl_cur) + header_ext + EW'(1);
        payload_last = EW'(decl_cur) + header_ext;
        payload_pos  = count_ext - header_ext - EW'(1);

        byte_count_next      = byte_count_reg;
        declared_length_next = declared_length_reg;
        length_low_next      = length_low_reg;
        running_xor_next     = running_xor_reg;
        held_id_next         = held_id_reg;
        held_sequence_next   = held_sequence_reg;
        res_load             = 1'b0;
        res_new              = '0;

        if (rx_accept)
        begin
            priority if (byte_count_reg == '0 && b != start_byte_reg)
            begin
                // hunting: drop anything but the start byte
            end
            else if (byte_count_reg >= CW'(BUFFER_BYTES))
            begin
                // buffer full: drop this byte, resume hunting silently
                byte_count_next = '0;
            end
            else
            begin
                byte_count_next = count_inc;
                if (count_inc == CW'(1))
                begin
                    running_xor_next = b;
                end
                else
                begin
                    if (count_inc == CW'(2))
                        length_low_next = b;
                    declared_length_next = decl_cur;

                    if (count_ext == total)
                    begin
                        // checksum byte: report status and resume hunting
                        res_load                   = 1'b1;
                        res_new.result_kind        = stxlxfr_pkg::KIND_FRAME_END;
                        res_new.message_id         = held_id_reg;
                        res_new.sequence_res       = seq_enable_reg ? held_sequence_reg : 8'd0;
                        res_new.payload_length     = decl_cur;
                        priority if (decl_cur > 16'(MAX_PAYLOAD))
                            res_new.frame_status = stxlxfr_pkg::STATUS_OVERSIZE;
                        else if (b != running_xor_reg)
                            res_new.frame_status = stxlxfr_pkg::STATUS_CHECKSUM;
                        else
                            res_new.frame_status = stxlxfr_pkg::STATUS_OK;
                        byte_count_next      = '0;
                        declared_length_next = '0;
                    end
                    else
                    begin
                        running_xor_next = running_xor_reg ^ b;
                        if (seq_enable_reg && count_inc == CW'(4))
                            held_sequence_next = b;
                        if (count_ext == header_ext)
                            held_id_next = b;

                        if (count_ext > header_ext && count_ext <= payload_last)
                        begin
                            res_load               = 1'b1;
                            res_new.result_kind    = stxlxfr_pkg::KIND_PAYLOAD;
                            res_new.payload_byte   = b;
                            res_new.byte_index     = payload_pos[7:0];
                            res_new.message_id     = (count_ext == header_ext) ? b
                                                                               : held_id_reg;
                            res_new.sequence_res   = seq_enable_reg ? held_sequence_next
                                                                    : 8'd0;
                            res_new.payload_length = decl_cur;
                            res_new.frame_status   = stxlxfr_pkg::STATUS_OK;
                        end
                    end
                end
            end
        end
    end

    // Output register: load on a new result, clear once taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_data_next  = res_new;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            declared_length_reg <= '0;
            length_low_reg      <= '0;
            running_xor_reg     <= '0;
            held_id_reg         <= '0;
            held_sequence_reg   <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            byte_count_reg      <= byte_count_next;
            declared_length_reg <= declared_length_next;
            length_low_reg      <= length_low_next;
            running_xor_reg     <= running_xor_next;
            held_id_reg         <= held_id_next;
            held_sequence_reg   <= held_sequence_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.result_kind    = res_data_reg.result_kind;
    assign res.payload_byte   = res_data_reg.payload_byte;
    assign res.byte_index     = res_data_reg.byte_index;
    assign res.message_id     = res_data_reg.message_id;
    assign res.sequence_res   = res_data_reg.sequence_res;
    assign res.payload_length = res_data_reg.payload_length;
    assign res.frame_status   = res_data_reg.frame_status;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `STXLXFR_ASSERT_NXT(a_end_resumes_hunt, res_load && res_new.result_kind == stxlxfr_pkg::KIND_FRAME_END, byte_count_reg == '0, "frame end did not return to hunting")
    `STXLXFR_ASSERT_NXT(a_hunt_drops_noise, rx_accept && byte_count_reg == '0 && rx.rx_byte != start_byte_reg, byte_count_reg == '0 && res_valid_reg == $past(res_valid_reg && !res.ready), "non-start byte left hunting or made a result")
    `STXLXFR_ASSERT_NXT(a_payload_status_ok, res_load && res_new.result_kind == stxlxfr_pkg::KIND_PAYLOAD, res_valid_reg && res_data_reg.frame_status == stxlxfr_pkg::STATUS_OK, "payload result carries a status")

endmodule
